[rtl/ffsa_pkg.sv]
package ffsa_pkg;

    localparam int CMD_W       = 1;
    localparam int OWNER_ID_W  = 8;
    localparam int SIZE_W      = 11;
    localparam int START_IDX_W = 10;
    localparam int STATUS_W    = 2;
    localparam int HEAP_CFG_W  = 11;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int HEAP_WORDS_DEF   = 1024;
    localparam int OWNER_BITS_DEF   = 8;
    localparam int HEAP_RESET       = 1024;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

[rtl/ffsa_req_if.sv]
interface ffsa_req_if import ffsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [OWNER_ID_W-1:0] owner_id;
    logic [SIZE_W-1:0]     req_size;
    logic [START_IDX_W-1:0] block_start;

    modport source (output valid, cmd, owner_id, req_size, block_start, input ready);
    modport sink   (input valid, cmd, owner_id, req_size, block_start, output ready);
endinterface

[rtl/ffsa_rsp_if.sv]
interface ffsa_rsp_if import ffsa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_status                status;
    logic [START_IDX_W-1:0] start_index;

    modport source (output valid, status, start_index, input ready);
    modport sink   (input valid, status, start_index, output ready);
endinterface

[rtl/first_fit_segment_allocator.sv]
// First-fit heap segment allocator. One request is in flight at a time; i_req.ready is high
// only while the block is idle. Requests scan the segment table one entry per cycle through
// its single registered read port. A split allocate then moves each later entry up one slot
// before writing the split and allocated entries, and a free that merges writes the merged
// entry and then moves each later entry down. The scan and the shift share the table between
// them. A heap size write taken while the block is idle reloads the table in the cycle after
// the last write, during which no request is taken. Results wait in an output register, so
// the next request can start before the previous result transfers.
module first_fit_segment_allocator import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int HEAP_WORDS   = HEAP_WORDS_DEF,
    parameter int OWNER_BITS   = OWNER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [HEAP_CFG_W-1:0] i_cfg_wdata,
    ffsa_req_if.sink              i_req,
    ffsa_rsp_if.source            o_rsp
);

    localparam int START_W = $clog2(HEAP_WORDS);
    localparam int LEN_W   = $clog2(HEAP_WORDS + 1);
    localparam int VW      = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
    localparam int ENT_W   = START_W + LEN_W + OWNER_BITS + 1;
    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam logic [LEN_W-1:0] HEAP_RST =
        LEN_W'((HEAP_WORDS < HEAP_RESET) ? HEAP_WORDS : HEAP_RESET);

    logic [LEN_W-1:0] r_heap;
    logic [LEN_W-1:0] n_heap;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [ENT_W-1:0] w_rdata;
    logic [VW-1:0]    w_ua;
    logic [VW-1:0]    w_ub;
    logic             w_usub;
    logic [VW-1:0]    w_usum;
    logic             w_ucarry;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_heap = LEN_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(HEAP_WORDS)) begin
            n_heap = LEN_W'(HEAP_WORDS);
        end else begin
            n_heap = LEN_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= HEAP_RST;
        end else if (i_cfg_we) begin
            r_heap <= n_heap;
        end
    end

    ffsa_seq #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .START_W      (START_W),
        .LEN_W        (LEN_W),
        .OWNER_BITS   (OWNER_BITS),
        .VW           (VW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_init   (i_cfg_we),
        .i_heap   (r_heap),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_ua     (w_ua),
        .o_ub     (w_ub),
        .o_usub   (w_usub),
        .i_usum   (w_usum),
        .i_ucarry (w_ucarry)
    );

    ffsa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffsa_addsub #(
        .W (VW)
    ) u_addsub (
        .i_a     (w_ua),
        .i_b     (w_ub),
        .i_sub   (w_usub),
        .o_sum   (w_usum),
        .o_carry (w_ucarry)
    );

endmodule

[rtl/ffsa_seg_ram.sv]
module ffsa_seg_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffsa_addsub.sv]
module ffsa_addsub #(
    parameter int W = 11
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);

    // subtract: carry set means a >= b
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (W+1)'(i_sub);

endmodule

[rtl/ffsa_seq.sv]
module ffsa_seq import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int START_W      = 10,
    parameter int LEN_W        = 11,
    parameter int OWNER_BITS   = OWNER_BITS_DEF,
    parameter int VW           = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_init,
    input  logic [LEN_W-1:0]                  i_heap,
    ffsa_req_if.sink                          i_req,
    ffsa_rsp_if.source                        o_rsp,
    output logic                              o_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   o_waddr,
    output logic [START_W+LEN_W+OWNER_BITS:0] o_wdata,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   o_raddr,
    input  logic [START_W+LEN_W+OWNER_BITS:0] i_rdata,
    output logic [VW-1:0]                     o_ua,
    output logic [VW-1:0]                     o_ub,
    output logic                              o_usub,
    input  logic [VW-1:0]                     i_usum,
    input  logic                              i_ucarry
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SW    = (START_W > START_IDX_W) ? START_W : START_IDX_W;

    typedef struct packed {
        logic [START_W-1:0]    start;
        logic [LEN_W-1:0]      len;
        logic [OWNER_BITS-1:0] owner;
        logic                  free;
    } t_seg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FNEXT,
        S_FPREV,
        S_WMERGE,
        S_SHDN,
        S_SHUP,
        S_WSPLIT,
        S_WALLOC,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_ptr;
    logic [CNT_W-1:0]       r_cidx;
    logic [CNT_W-1:0]       r_hit;
    logic [CNT_W-1:0]       r_last;
    logic [IDX_W-1:0]       r_wa;
    logic                   r_wvld;
    logic                   r_rdone;
    logic [CMD_W-1:0]       r_cmd;
    logic [OWNER_BITS-1:0]  r_owner;
    logic [SIZE_W-1:0]      r_req;
    logic [START_IDX_W-1:0] r_bstart;
    t_seg                   r_ent;
    t_seg                   r_prev;
    logic                   r_pfree;
    logic                   r_nfree;
    logic [1:0]             r_delta;
    logic [LEN_W-1:0]       r_acc;
    logic [LEN_W-1:0]       r_diff;
    t_status                r_res_status;
    logic [START_IDX_W-1:0] r_res_start;
    logic                   r_ovld;
    t_status                r_status;
    logic [START_IDX_W-1:0] r_start;

    t_seg               w_rd;
    t_seg               w_wseg;
    logic               w_ready;
    logic               w_fit;
    logic               w_match;
    logic               w_hit;
    logic               w_last;
    logic               w_nfree;
    logic [1:0]         w_delta;
    logic [CNT_W:0]     w_src;
    logic [CNT_W-1:0]   w_cm1;

    assign w_rd    = t_seg'(i_rdata);
    assign w_cm1   = r_count - CNT_W'(1);
    assign w_ready = (r_state == S_IDLE) && !i_init;
    assign w_fit   = w_rd.free && i_ucarry;
    assign w_match = !w_rd.free && (w_rd.owner == r_owner) &&
                     (SW'(w_rd.start) == SW'(r_bstart));
    assign w_hit   = (r_cmd == CMD_ALLOC) ? w_fit : w_match;
    assign w_last  = (r_cidx == w_cm1);
    assign w_nfree = (r_hit != w_cm1) && w_rd.free;
    assign w_delta = {1'b0, r_pfree} + {1'b0, r_nfree};
    assign w_src   = {1'b0, r_hit} + (CNT_W+1)'(1) + (CNT_W+1)'(r_nfree);

    assign i_req.ready       = w_ready;
    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_status;
    assign o_rsp.start_index = r_start;
    assign o_raddr           = r_ptr[IDX_W-1:0];
    assign o_wdata           = w_wseg;

    always_comb begin
        o_ua   = '0;
        o_ub   = '0;
        o_usub = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                o_ua   = VW'(w_rd.len);
                o_ub   = VW'(r_req);
                o_usub = 1'b1;
            end
            S_FNEXT: begin
                o_ua = VW'(r_ent.len);
                o_ub = VW'(w_rd.len);
            end
            S_FPREV: begin
                o_ua = VW'(r_acc);
                o_ub = VW'(r_prev.len);
            end
            S_WSPLIT: begin
                o_ua = VW'(r_ent.start);
                o_ub = VW'(r_req);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_hit[IDX_W-1:0];
        w_wseg  = r_ent;
        unique case (r_state)
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                w_wseg  = '{start: '0, len: i_heap, owner: '0, free: 1'b1};
            end
            S_WMERGE: begin
                o_we    = 1'b1;
                o_waddr = r_pfree ? IDX_W'(r_hit - CNT_W'(1)) : r_hit[IDX_W-1:0];
                w_wseg  = '{start: (r_pfree ? r_prev.start : r_ent.start),
                            len: r_acc, owner: '0, free: 1'b1};
            end
            S_SHDN, S_SHUP: begin
                o_we    = r_wvld;
                o_waddr = r_wa;
                w_wseg  = w_rd;
            end
            S_WSPLIT: begin
                o_we    = 1'b1;
                o_waddr = IDX_W'(r_hit + CNT_W'(1));
                w_wseg  = '{start: i_usum[START_W-1:0], len: r_diff, owner: '0, free: 1'b1};
            end
            S_WALLOC: begin
                o_we    = 1'b1;
                w_wseg  = '{start: r_ent.start, len: LEN_W'(r_req), owner: r_owner,
                            free: 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CNT_W'(1);
            r_ptr   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (r_ovld && o_rsp.ready && r_state != S_DONE) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_count <= CNT_W'(1);
                    r_ptr   <= '0;
                    if (!i_init) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_init) begin
                        r_state <= S_INIT;
                    end else if (i_req.valid) begin
                        r_cmd    <= i_req.cmd;
                        r_owner  <= OWNER_BITS'(i_req.owner_id);
                        r_req    <= i_req.req_size;
                        r_bstart <= i_req.block_start;
                        r_pfree  <= 1'b0;
                        if (i_req.cmd == CMD_ALLOC && i_req.req_size == '0) begin
                            r_res_status <= ST_MISS;
                            r_res_start  <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_ptr   <= CNT_W'(1);
                            r_cidx  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_hit <= r_cidx;
                        r_ent <= w_rd;
                        if (r_cmd == CMD_ALLOC) begin
                            if (i_usum != '0) begin
                                if (r_count >= CNT_W'(MAX_SEGMENTS)) begin
                                    r_res_status <= ST_FULL;
                                    r_res_start  <= '0;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_diff <= i_usum[LEN_W-1:0];
                                    if (!w_last) begin
                                        r_ptr   <= w_cm1;
                                        r_last  <= r_cidx + CNT_W'(1);
                                        r_wvld  <= 1'b0;
                                        r_rdone <= 1'b0;
                                        r_state <= S_SHUP;
                                    end else begin
                                        r_state <= S_WSPLIT;
                                    end
                                end
                            end else begin
                                r_state <= S_WALLOC;
                            end
                        end else begin
                            r_pfree <= (r_cidx != '0) && r_prev.free;
                            r_state <= S_FNEXT;
                        end
                    end else if (w_last) begin
                        r_res_status <= ST_MISS;
                        r_res_start  <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_prev <= w_rd;
                        r_cidx <= r_cidx + CNT_W'(1);
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end
                end
                S_FNEXT: begin
                    r_nfree <= w_nfree;
                    r_acc   <= w_nfree ? i_usum[LEN_W-1:0] : r_ent.len;
                    r_state <= S_FPREV;
                end
                S_FPREV: begin
                    if (r_pfree) begin
                        r_acc <= i_usum[LEN_W-1:0];
                    end
                    r_state <= S_WMERGE;
                end
                S_WMERGE: begin
                    r_delta <= w_delta;
                    r_count <= r_count - CNT_W'(w_delta);
                    r_last  <= w_cm1;
                    r_wvld  <= 1'b0;
                    r_rdone <= 1'b0;
                    if (w_delta == '0 || w_src > {1'b0, w_cm1}) begin
                        r_res_status <= ST_OK;
                        r_res_start  <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_ptr   <= CNT_W'(w_src);
                        r_state <= S_SHDN;
                    end
                end
                S_SHDN: begin
                    if (r_rdone) begin
                        r_wvld       <= 1'b0;
                        r_res_status <= ST_OK;
                        r_res_start  <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_wa    <= IDX_W'(r_ptr - CNT_W'(r_delta));
                        r_wvld  <= 1'b1;
                        r_rdone <= (r_ptr == r_last);
                        r_ptr   <= r_ptr + CNT_W'(1);
                    end
                end
                S_SHUP: begin
                    if (r_rdone) begin
                        r_wvld  <= 1'b0;
                        r_state <= S_WSPLIT;
                    end else begin
                        r_wa    <= IDX_W'(r_ptr + CNT_W'(1));
                        r_wvld  <= 1'b1;
                        r_rdone <= (r_ptr == r_last);
                        r_ptr   <= r_ptr - CNT_W'(1);
                    end
                end
                S_WSPLIT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_WALLOC;
                end
                S_WALLOC: begin
                    r_res_status <= ST_OK;
                    r_res_start  <= START_IDX_W'(r_ent.start);
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovld || o_rsp.ready) begin
                        r_ovld   <= 1'b1;
                        r_status <= r_res_status;
                        r_start  <= r_res_start;
                        r_ptr    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

endmodule

[dv/first_fit_segment_allocator_checker.sv]
module first_fit_segment_allocator_checker import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int HEAP_WORDS   = HEAP_WORDS_DEF,
    parameter int OWNER_BITS   = OWNER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [HEAP_CFG_W-1:0] i_cfg_wdata,
    ffsa_req_if                   i_req,
    ffsa_rsp_if                   i_rsp,
    output int                    o_fail_count,
    output int                    o_owed_count,
    output int                    o_ok_count,
    output int                    o_miss_count,
    output int                    o_full_count,
    output int                    o_merge_count
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [START_IDX_W-1:0] start;
        logic [SIZE_W-1:0]      length;
        logic [OWNER_ID_W-1:0]  owner;
        logic                   is_free;
    } segment_t;

    typedef struct packed {
        t_status                status;
        logic [START_IDX_W-1:0] start_index;
    } reply_t;

    segment_t          seg_tab [MAX_SEGMENTS];
    int                seg_count;
    logic [SIZE_W-1:0] heap_words;
    reply_t            owed_replies [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < MAX_PRINTED) begin
            $display("[%0t] checker: %s: got %0d, expected %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    function automatic void load_heap(input logic [HEAP_CFG_W-1:0] value);
        int words;
        words = int'(value);
        if (words < 1) words = 1;
        if (words > HEAP_WORDS) words = HEAP_WORDS;
        heap_words = SIZE_W'(words);
        foreach (seg_tab[k]) seg_tab[k] = '0;
        seg_tab[0].length  = heap_words;
        seg_tab[0].is_free = 1'b1;
        seg_count = 1;
    endfunction

    function automatic void drop_segment(input int idx);
        int k;
        for (k = idx; k + 1 < seg_count; k++) seg_tab[k] = seg_tab[k+1];
        seg_count--;
        seg_tab[seg_count] = '0;
    endfunction

    function automatic reply_t serve_request(input logic [CMD_W-1:0]       cmd,
                                             input logic [OWNER_ID_W-1:0]  owner_id,
                                             input logic [SIZE_W-1:0]      req_size,
                                             input logic [START_IDX_W-1:0] block_start);
        reply_t                r;
        logic [OWNER_ID_W-1:0] owner_key;
        int                    hit;
        int                    k;
        r.status      = ST_MISS;
        r.start_index = '0;
        owner_key     = owner_id & OWNER_ID_W'((1 << OWNER_BITS) - 1);
        hit           = -1;
        if (cmd == CMD_ALLOC) begin
            if (req_size != '0) begin
                for (k = 0; k < seg_count; k++) begin
                    if (hit < 0 && seg_tab[k].is_free && seg_tab[k].length >= req_size) hit = k;
                end
                if (hit >= 0) begin
                    if (seg_tab[hit].length > req_size && seg_count >= MAX_SEGMENTS) begin
                        r.status = ST_FULL;
                    end else begin
                        if (seg_tab[hit].length > req_size) begin
                            for (k = seg_count; k > hit + 1; k--) seg_tab[k] = seg_tab[k-1];
                            seg_tab[hit+1].start   = seg_tab[hit].start + START_IDX_W'(req_size);
                            seg_tab[hit+1].length  = seg_tab[hit].length - req_size;
                            seg_tab[hit+1].owner   = '0;
                            seg_tab[hit+1].is_free = 1'b1;
                            seg_count++;
                        end
                        seg_tab[hit].length  = req_size;
                        seg_tab[hit].owner   = owner_key;
                        seg_tab[hit].is_free = 1'b0;
                        r.status      = ST_OK;
                        r.start_index = seg_tab[hit].start;
                    end
                end
            end
        end else begin
            for (k = 0; k < seg_count; k++) begin
                if (hit < 0 && !seg_tab[k].is_free && seg_tab[k].owner == owner_key &&
                    seg_tab[k].start == block_start) hit = k;
            end
            if (hit >= 0) begin
                if (hit > 0 && seg_tab[hit-1].is_free) begin
                    seg_tab[hit-1].length += seg_tab[hit].length;
                    drop_segment(hit);
                    hit--;
                    o_merge_count++;
                end
                if (hit + 1 < seg_count && seg_tab[hit+1].is_free) begin
                    seg_tab[hit].length += seg_tab[hit+1].length;
                    drop_segment(hit + 1);
                    o_merge_count++;
                end
                seg_tab[hit].is_free = 1'b1;
                seg_tab[hit].owner   = '0;
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        reply_t want;
        if (!i_rst_n) begin
            load_heap(HEAP_CFG_W'(HEAP_RESET));
            owed_replies.delete();
        end else begin
            if (i_cfg_we) load_heap(i_cfg_wdata);
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch("result with no request outstanding", int'(i_rsp.status), -1);
                end else begin
                    want = owed_replies.pop_front();
                    case (want.status)
                        ST_OK:   o_ok_count++;
                        ST_FULL: o_full_count++;
                        default: o_miss_count++;
                    endcase
                    if (i_rsp.status !== want.status) begin
                        report_mismatch("status", int'(i_rsp.status), int'(want.status));
                    end
                    if (i_rsp.start_index !== want.start_index) begin
                        report_mismatch("start_index", int'(i_rsp.start_index),
                                        int'(want.start_index));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                owed_replies.push_back(serve_request(i_req.cmd, i_req.owner_id, i_req.req_size,
                                                     i_req.block_start));
            end
        end
        o_owed_count = owed_replies.size();
    end

endmodule

[dv/first_fit_segment_allocator_tb.sv]
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 2 * MAX_SEGMENTS_DEF + 16;
    localparam int PHASE_ITEMS    = 115;
    localparam int HOLD_AT_REPLY  = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int STRETCH_PERIOD = 100;
    localparam int STRETCH_LEN    = 25;

    typedef struct {
        logic [OWNER_ID_W-1:0]  owner;
        logic [START_IDX_W-1:0] base;
    } block_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [HEAP_CFG_W-1:0] cfg_wdata;

    ffsa_req_if req_ch ();
    ffsa_rsp_if rsp_ch ();

    int fail_count;
    int owed_count;
    int ok_count;
    int miss_count;
    int full_count;
    int merge_count;

    int                    heap_now;
    int                    requests_sent;
    int                    replies_taken;
    int                    cycle_count;
    block_t                held_blocks [$];
    logic [CMD_W-1:0]      sent_cmds   [$];
    logic [OWNER_ID_W-1:0] sent_owners [$];

    first_fit_segment_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    first_fit_segment_allocator_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_owed_count  (owed_count),
        .o_ok_count    (ok_count),
        .o_miss_count  (miss_count),
        .o_full_count  (full_count),
        .o_merge_count (merge_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("first_fit_segment_allocator_tb: FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [CMD_W-1:0]       cmd,
                                input logic [OWNER_ID_W-1:0]  owner,
                                input logic [SIZE_W-1:0]      size,
                                input logic [START_IDX_W-1:0] blk);
        int gap;
        gap = (requests_sent % STRETCH_PERIOD < STRETCH_LEN) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.owner_id    <= owner;
        req_ch.req_size    <= size;
        req_ch.block_start <= blk;
        @(posedge clk);
        while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
        sent_cmds.push_back(cmd);
        sent_owners.push_back(owner);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (owed_count != 0) @(negedge clk);
    endtask

    task automatic write_heap(input logic [HEAP_CFG_W-1:0] value);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        held_blocks.delete();
        heap_now = (value == '0) ? 1 : (int'(value) > HEAP_WORDS_DEF ? HEAP_WORDS_DEF : int'(value));
    endtask

    task automatic send_random_request();
        int                pick;
        int                idx;
        block_t            b;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) size = SIZE_W'($urandom_range(1, heap_now));
            else size = SIZE_W'($urandom_range(1, heap_now / 8 + 1));
            send_request(CMD_ALLOC, OWNER_ID_W'($urandom_range(0, 255)), size,
                         START_IDX_W'($urandom_range(0, 1023)));
        end else if (pick < 88 && held_blocks.size() > 0) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[idx];
            held_blocks.delete(idx);
            send_request(CMD_FREE, b.owner, SIZE_W'($urandom_range(0, 2047)), b.base);
        end else begin
            case ($urandom_range(0, 3))
                0: send_request(CMD_ALLOC, OWNER_ID_W'($urandom_range(0, 255)), '0,
                                START_IDX_W'($urandom_range(0, 1023)));
                1: send_request(CMD_ALLOC, OWNER_ID_W'($urandom_range(0, 255)),
                                SIZE_W'($urandom_range(0, 2047)),
                                START_IDX_W'($urandom_range(0, 1023)));
                2: send_request(CMD_FREE, OWNER_ID_W'($urandom_range(0, 255)),
                                SIZE_W'($urandom_range(0, 2047)),
                                START_IDX_W'($urandom_range(0, 1023)));
                default: begin
                    if (held_blocks.size() > 0) begin
                        b = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                        send_request(CMD_FREE, b.owner + 1'b1, '0, b.base);
                    end else begin
                        send_request(CMD_FREE, '0, '0, START_IDX_W'($urandom_range(0, 1023)));
                    end
                end
            endcase
        end
    endtask

    initial begin : reply_sink
        int                    gap;
        logic [CMD_W-1:0]      cmd;
        logic [OWNER_ID_W-1:0] owner;
        rsp_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (replies_taken == HOLD_AT_REPLY) gap = HOLD_CYCLES;
            else if (replies_taken % STRETCH_PERIOD >= 50 &&
                     replies_taken % STRETCH_PERIOD < 50 + STRETCH_LEN) gap = 0;
            else gap = $urandom_range(0, 9);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
            replies_taken++;
            cmd   = sent_cmds.pop_front();
            owner = sent_owners.pop_front();
            if (cmd == CMD_ALLOC && rsp_ch.status == ST_OK) begin
                held_blocks.push_back('{owner, rsp_ch.start_index});
            end
            @(negedge clk);
        end
    end

    initial begin : stimulus
        logic [HEAP_CFG_W-1:0] heap_plan [8];
        int                    p;
        int                    n;
        int                    s;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_ALLOC;
        req_ch.owner_id    = '0;
        req_ch.req_size    = '0;
        req_ch.block_start = '0;
        heap_now           = HEAP_RESET;
        heap_plan = '{11'd0, 11'd2047, 11'd2, 11'd37, 11'd1000, 11'd1025, 11'd300, 11'd0};
        heap_plan[7] = HEAP_CFG_W'($urandom_range(3, 1023));
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(CMD_ALLOC, 8'h5A, '0, 10'h3FF);
        send_request(CMD_ALLOC, 8'hFF, 11'h7FF, '0);
        // owner 0 on a free segment never matches
        send_request(CMD_FREE, '0, '0, '0);
        send_request(CMD_ALLOC, '0, 11'd2, 10'h3FF);
        for (s = 2; s < 16; s++) begin
            send_request(CMD_ALLOC, OWNER_ID_W'(s * 17), 11'd1, '0);
        end
        send_request(CMD_FREE, '0, 11'h7FF, '0);
        send_request(CMD_FREE, 8'd85, '0, 10'd5);
        // first fit needs a split but the table is full; later exact fit is skipped
        send_request(CMD_ALLOC, 8'hFF, 11'd1, '0);
        send_request(CMD_FREE, 8'd68, '0, 10'd4);
        send_request(CMD_FREE, 8'd52, '0, 10'd3);
        send_request(CMD_FREE, 8'd102, '0, 10'd6);
        send_request(CMD_FREE, 8'd34, '0, 10'd2);
        send_request(CMD_FREE, 8'd51, '0, 10'd3);
        send_request(CMD_ALLOC, 8'hFF, 11'd7, '0);

        for (p = 0; p < 8; p++) begin
            write_heap(heap_plan[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) wait_idle();
                send_random_request();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("first_fit_segment_allocator_tb: %0d request transfers over %0d heap sizes",
                 requests_sent, 9);
        $display("first_fit_segment_allocator_tb: %0d granted/freed, %0d missed, %0d table full, %0d merges",
                 ok_count, miss_count, full_count, merge_count);
        if (fail_count == 0 && owed_count == 0) begin
            $display("first_fit_segment_allocator_tb: PASS");
        end else begin
            $display("first_fit_segment_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

[first_fit_segment_allocator.f]
rtl/ffsa_pkg.sv
rtl/ffsa_req_if.sv
rtl/ffsa_rsp_if.sv
rtl/ffsa_seg_ram.sv
rtl/ffsa_addsub.sv
rtl/ffsa_seq.sv
rtl/first_fit_segment_allocator.sv
dv/first_fit_segment_allocator_checker.sv
dv/first_fit_segment_allocator_tb.sv
